// File: rtl/core/rsac_pkg.sv
package rsac_pkg;

	// Fixed widths of the stream fields and configuration data
	localparam int DATA_BITS = 32;
	localparam int CFG_IDX_BITS = 2;

	// Width of the modular datapath; key and value bits above it are ignored
	localparam int WORD_BITS = 32;
	localparam int CNT_BITS = $clog2(WORD_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

	// Symbol range accepted on decrypt
	localparam int SYM_BITS = 6;
	localparam int SYM_MAX = 42;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS = 2'd2;

	// Direction codes
	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	// Configuration reset values
	localparam logic [DATA_BITS-1:0] EXPONENT_RESET = 32'd7;
	localparam logic [DATA_BITS-1:0] MODULUS_RESET = 32'd187;

	typedef logic [WORD_BITS-1:0] word_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;       // latch request, start base reduction
		logic start_mul;  // start square and multiply for one exponent bit
		logic step;       // one bit step of both modular multipliers
		logic commit_pre; // store reduced base
		logic commit_mul; // store square, product and shift exponent
		logic out_load;   // load the output register
	} rsac_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic in_ok;  // request produces work
		logic k_zero; // no exponent bits left
		logic res_ok; // final value gives a result
	} rsac_sts_t;

	// One step of interleaved modular multiply: r = (2r + xbit * a) mod m.
	// r and a are below m; a zero modulus wraps at 2^WORD_BITS.
	function automatic word_t modmul_step(word_t r, word_t a, logic xbit, word_t m);
		logic [WORD_BITS:0] t;
		logic [WORD_BITS:0] u;
		logic mz;
		mz = (m == '0);
		t = {r, 1'b0};
		if (!mz && t >= {1'b0, m})
			t = t - {1'b0, m};
		u = t;
		if (xbit)
			u = t + {1'b0, a};
		if (!mz && u >= {1'b0, m})
			u = u - {1'b0, m};
		return u[WORD_BITS-1:0];
	endfunction

	// Character code to symbol number, zero when not in the table
	function automatic logic [SYM_BITS-1:0] char_to_symbol(logic [7:0] ch);
		logic [SYM_BITS-1:0] s;
		s = '0;
		if (ch >= 8'h41 && ch <= 8'h5A)
			s = SYM_BITS'(ch - 8'h40);
		else if (ch >= 8'h30 && ch <= 8'h39)
			s = SYM_BITS'(ch - 8'h15);
		else if (ch >= 8'h61 && ch <= 8'h66)
			s = SYM_BITS'(ch - 8'h3C);
		return s;
	endfunction

	// Symbol number 1-42 back to its character code
	function automatic logic [7:0] symbol_to_char(logic [SYM_BITS-1:0] s);
		logic [7:0] c;
		if (s <= 6'd26)
			c = 8'({2'b00, s} + 8'h40);
		else if (s <= 6'd36)
			c = 8'({2'b00, s} + 8'h15);
		else
			c = 8'({2'b00, s} + 8'h3C);
		return c;
	endfunction

endpackage

// File: rtl/core/rsac_ctrl.sv
module rsac_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  rsac_pkg::rsac_sts_t sts,
	output rsac_pkg::rsac_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_CHECK,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [rsac_pkg::CNT_BITS-1:0] cnt_q;
	logic                          m_valid_q;
	logic                          last;

	assign last = (cnt_q == rsac_pkg::CNT_LAST);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

	// Command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = s_tvalid && sts.in_ok;
			end
			ST_PRE: begin
				cmd.step = 1'b1;
				cmd.commit_pre = last;
			end
			ST_CHECK: begin
				cmd.start_mul = !sts.k_zero;
			end
			ST_MUL: begin
				cmd.step = 1'b1;
				cmd.commit_mul = last;
			end
			ST_DONE: begin
				cmd.out_load = sts.res_ok && (!m_valid_q || m_tready);
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State, bit counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.load)
						state_q <= ST_PRE;
				end
				ST_PRE: begin
					cnt_q <= cnt_q + 1'b1;
					if (last)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					cnt_q <= '0;
					state_q <= sts.k_zero ? ST_DONE : ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (last)
						state_q <= ST_CHECK;
				end
				ST_DONE: begin
					if (!sts.res_ok || !m_valid_q || m_tready)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.out_load && m_valid_q && !m_tready))
		else $error("output register overwritten while stalled");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.start_mul, cmd.step, cmd.out_load}))
		else $error("conflicting datapath commands");

	a_commit_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit_pre || cmd.commit_mul) |-> (cmd.step && last))
		else $error("commit outside the last multiply step");

	a_mul_follows_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_mul |=> (state_q == ST_MUL && cnt_q == '0))
		else $error("multiply did not start from a cleared counter");

endmodule

// File: rtl/core/rsac_dpath.sv
module rsac_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rsac_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [rsac_pkg::DATA_BITS-1:0]        cfg_data,
	input  logic [rsac_pkg::DATA_BITS-1:0]        in_data,
	output logic [rsac_pkg::DATA_BITS-1:0]        out_data,
	input  rsac_pkg::rsac_cmd_t                   cmd,
	output rsac_pkg::rsac_sts_t                   sts
);

	logic                  dir_q;
	rsac_pkg::word_t       exp_q;
	rsac_pkg::word_t       mod_q;
	rsac_pkg::word_t       k_q;
	rsac_pkg::word_t       acc_q;
	rsac_pkg::word_t       b_q;
	rsac_pkg::word_t       ra_q;
	rsac_pkg::word_t       rb_q;
	rsac_pkg::word_t       aa_q;
	rsac_pkg::word_t       ab_q;
	rsac_pkg::word_t       xa_q;
	rsac_pkg::word_t       xb_q;
	logic [rsac_pkg::DATA_BITS-1:0] out_q;

	logic [rsac_pkg::SYM_BITS-1:0] sym;
	rsac_pkg::word_t       ra_next;
	rsac_pkg::word_t       rb_next;
	rsac_pkg::word_t       base;
	logic                  acc_in_range;

	// Input decode
	assign sym = rsac_pkg::char_to_symbol(in_data[7:0]);
	assign base = (dir_q == rsac_pkg::DIR_DECRYPT) ? in_data[rsac_pkg::WORD_BITS-1:0]
		: rsac_pkg::WORD_BITS'(sym);

	// Two modular multipliers, one bit of x per step
	assign ra_next = rsac_pkg::modmul_step(ra_q, aa_q, xa_q[rsac_pkg::WORD_BITS-1], mod_q);
	assign rb_next = rsac_pkg::modmul_step(rb_q, ab_q, xb_q[rsac_pkg::WORD_BITS-1], mod_q);

	assign acc_in_range = (acc_q >= rsac_pkg::WORD_BITS'(1))
		&& (acc_q <= rsac_pkg::WORD_BITS'(rsac_pkg::SYM_MAX));

	// Status to the controller
	assign sts.in_ok = (dir_q == rsac_pkg::DIR_DECRYPT) || (sym != '0);
	assign sts.k_zero = (k_q == '0);
	assign sts.res_ok = (dir_q == rsac_pkg::DIR_ENCRYPT) || acc_in_range;

	assign out_data = out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= rsac_pkg::DIR_ENCRYPT;
			exp_q <= rsac_pkg::EXPONENT_RESET[rsac_pkg::WORD_BITS-1:0];
			mod_q <= rsac_pkg::MODULUS_RESET[rsac_pkg::WORD_BITS-1:0];
		end else if (cfg_we) begin
			case (cfg_index)
				rsac_pkg::REG_DIRECTION: dir_q <= cfg_data[0];
				rsac_pkg::REG_EXPONENT:  exp_q <= cfg_data[rsac_pkg::WORD_BITS-1:0];
				rsac_pkg::REG_MODULUS:   mod_q <= cfg_data[rsac_pkg::WORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Exponentiation registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// base reduction runs as base * 1 on multiplier b
			k_q <= exp_q;
			acc_q <= (mod_q == rsac_pkg::WORD_BITS'(1)) ? '0 : rsac_pkg::WORD_BITS'(1);
			rb_q <= '0;
			ab_q <= rsac_pkg::WORD_BITS'(1);
			xb_q <= base;
		end
		if (cmd.start_mul) begin
			ra_q <= '0;
			aa_q <= acc_q;
			xa_q <= b_q;
			rb_q <= '0;
			ab_q <= b_q;
			xb_q <= b_q;
		end
		if (cmd.step) begin
			ra_q <= ra_next;
			rb_q <= rb_next;
			xa_q <= {xa_q[rsac_pkg::WORD_BITS-2:0], 1'b0};
			xb_q <= {xb_q[rsac_pkg::WORD_BITS-2:0], 1'b0};
		end
		if (cmd.commit_pre)
			b_q <= rb_next;
		if (cmd.commit_mul) begin
			if (k_q[0])
				acc_q <= ra_next;
			b_q <= rb_next;
			k_q <= {1'b0, k_q[rsac_pkg::WORD_BITS-1:1]};
		end
		if (cmd.out_load)
			out_q <= (dir_q == rsac_pkg::DIR_DECRYPT)
				? rsac_pkg::DATA_BITS'(rsac_pkg::symbol_to_char(acc_q[rsac_pkg::SYM_BITS-1:0]))
				: rsac_pkg::DATA_BITS'(acc_q);
	end

endmodule

// File: rtl/core/char_rsa_coder.sv
// Character RSA coder.
// Input stream s_axis_*: one request per item; tdata is a character code in
// bits 7:0 (encrypt) or a cipher value (decrypt). Output stream m_axis_*:
// tdata is the cipher value (encrypt) or the character code (decrypt).
// Configuration: cfg_we/cfg_index/cfg_data write direction (0), exponent (1)
// and modulus (2); write only while the block is idle.
// A character outside A-Z, 0-9, a-f, or a decrypted value outside 1-42,
// produces no output item.
// Timing: one request at a time. Each modular multiply is bit-serial, one
// bit of the multiplier per cycle; square and multiply run on two units in
// parallel. Once the result is loaded into the output register, the block
// is idle again and takes the next request.
// The output register holds a result while the receiver stalls, and a new
// request is accepted meanwhile; a second result waits until the first is
// taken.
// Reset: direction 0, exponent 7, modulus 187, both streams empty.
module char_rsa_coder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rsac_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [rsac_pkg::DATA_BITS-1:0]    cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [rsac_pkg::DATA_BITS-1:0]    s_axis_tdata,  // [31:0] data_in
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [rsac_pkg::DATA_BITS-1:0]    m_axis_tdata   // [31:0] data_out
);

	rsac_pkg::rsac_cmd_t cmd;
	rsac_pkg::rsac_sts_t sts;

	// Controller
	rsac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	rsac_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: test/rsa_coder_check.sv
module rsa_coder_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rsac_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [rsac_pkg::DATA_BITS-1:0]    cfg_data,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic [rsac_pkg::DATA_BITS-1:0]    s_axis_tdata,  // [31:0] data_in
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [rsac_pkg::DATA_BITS-1:0]    m_axis_tdata,  // [31:0] data_out
	output int                                error_count,
	output int                                pending
);

	// Local copy of the key registers
	logic                           key_dir;
	logic [rsac_pkg::DATA_BITS-1:0] key_exp;
	logic [rsac_pkg::DATA_BITS-1:0] key_mod;

	// Coded values still owed by the block, oldest first
	logic [rsac_pkg::DATA_BITS-1:0] coded_queue[$];
	logic [rsac_pkg::DATA_BITS-1:0] coded_next;
	logic [rsac_pkg::DATA_BITS-1:0] coded_head;

	// Reduce a double-width value; a zero modulus wraps at 2^32
	function automatic logic [63:0] fold_mod(logic [63:0] x, logic [31:0] m);
		if (m == '0)
			return {32'b0, x[31:0]};
		return x % {32'b0, m};
	endfunction

	// Right-to-left square and multiply with full-width products
	function automatic logic [31:0] pow_mod(logic [31:0] base, logic [31:0] e, logic [31:0] m);
		logic [63:0] acc;
		logic [63:0] b;
		logic [31:0] k;
		acc = fold_mod(64'd1, m);
		b = fold_mod({32'b0, base}, m);
		k = e;
		while (k != '0) begin
			if (k[0])
				acc = fold_mod(acc * b, m);
			k = k >> 1;
			b = fold_mod(b * b, m);
		end
		return acc[31:0];
	endfunction

	// Character to symbol number, zero when not in the table
	function automatic logic [5:0] symbol_of(logic [7:0] c);
		if (c >= "A" && c <= "Z")
			return 6'(c - "A" + 1);
		if (c >= "0" && c <= "9")
			return 6'(c - "0" + 27);
		if (c >= "a" && c <= "f")
			return 6'(c - "a" + 37);
		return '0;
	endfunction

	// Symbol number 1-42 back to its character
	function automatic logic [7:0] char_of(logic [31:0] v);
		if (v <= 26)
			return 8'("A" + v - 1);
		if (v <= 36)
			return 8'("0" + v - 27);
		return 8'("a" + v - 37);
	endfunction

	// Coded value for one request; returns 0 when the block stays silent
	function automatic bit code_request(logic [31:0] din, output logic [31:0] dout);
		logic [5:0]  sym;
		logic [31:0] v;
		dout = '0;
		if (key_dir == rsac_pkg::DIR_ENCRYPT) begin
			sym = symbol_of(din[7:0]);
			if (sym == '0)
				return 1'b0;
			dout = pow_mod({26'b0, sym}, key_exp, key_mod);
			return 1'b1;
		end
		v = pow_mod(din, key_exp, key_mod);
		if (v < 1 || v > rsac_pkg::SYM_MAX)
			return 1'b0;
		dout = {24'b0, char_of(v)};
		return 1'b1;
	endfunction

	// Track writes, predict on accepted requests, compare on accepted results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_dir = rsac_pkg::DIR_ENCRYPT;
			key_exp = rsac_pkg::EXPONENT_RESET;
			key_mod = rsac_pkg::MODULUS_RESET;
			coded_queue.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (coded_queue.size() == 0) begin
					$error("data_out: no result expected, got %08h", m_axis_tdata);
					error_count++;
				end else begin
					coded_head = coded_queue.pop_front();
					if (coded_head !== m_axis_tdata) begin
						$error("data_out: expected %08h, got %08h", coded_head, m_axis_tdata);
						error_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready && code_request(s_axis_tdata, coded_next))
				coded_queue = {coded_queue, coded_next};
			if (cfg_we) begin
				case (cfg_index)
					rsac_pkg::REG_DIRECTION: key_dir = cfg_data[0];
					rsac_pkg::REG_EXPONENT:  key_exp = cfg_data;
					rsac_pkg::REG_MODULUS:   key_mod = cfg_data;
					default: ;
				endcase
			end
		end
		pending = coded_queue.size();
	end

endmodule

// File: test/testbench.sv
module testbench;

	localparam logic [rsac_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
	localparam int LATENCY_MAX = 1100;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int N_ITEMS = 1350;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 3000;
	localparam string CHAR_SET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789abcdef";

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [rsac_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [rsac_pkg::DATA_BITS-1:0]    cfg_data = '0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [rsac_pkg::DATA_BITS-1:0]    s_axis_tdata = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [rsac_pkg::DATA_BITS-1:0]    m_axis_tdata;

	int error_count;
	int pending;
	int sent = 0;
	int idle_mode = 0;
	logic                           cur_dir = rsac_pkg::DIR_ENCRYPT;
	logic [rsac_pkg::DATA_BITS-1:0] cur_mod = rsac_pkg::MODULUS_RESET;
	logic [rsac_pkg::DATA_BITS-1:0] cipher_pool[$];

	char_rsa_coder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	rsa_coder_check u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.error_count   (error_count),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Keep cipher values from encrypt runs to feed the decrypt runs
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready && cur_dir == rsac_pkg::DIR_ENCRYPT)
			cipher_pool = {cipher_pool, m_axis_tdata};
	end

	// Receiver: one long hold-off early on, otherwise random stalls per idle mode
	initial begin : rx_side
		bit held;
		held = 0;
		forever begin
			@(negedge clk);
			if (!held && sent >= HOLD_AT) begin
				held = 1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			case (idle_mode)
				0:       m_axis_tready <= ($urandom_range(0, 99) >= 74);
				1:       m_axis_tready <= ($urandom_range(0, 99) >= 37);
				default: m_axis_tready <= 1'b1;
			endcase
		end
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	// Offer one request; enters and leaves just after a falling edge
	task automatic push(input logic [rsac_pkg::DATA_BITS-1:0] d);
		idle_mode = (sent < 450) ? 0 : (sent < 900) ? 1 : 2;
		if (idle_mode != 2) begin
			while ($urandom_range(0, 99) < (idle_mode == 0 ? 37 : 74)) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		sent++;
	endtask

	// Drain the block, then load a new key set (plus a write to the spare index)
	task automatic set_keys(input logic dir, input logic [31:0] expo, input logic [31:0] modulus);
		logic [31:0] junk;
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY_MAX) @(negedge clk);
		junk = $urandom();
		cfg_we <= 1'b1;
		cfg_index <= rsac_pkg::REG_DIRECTION;
		cfg_data <= {junk[31:1], dir};
		@(negedge clk);
		cfg_index <= rsac_pkg::REG_EXPONENT;
		cfg_data <= expo;
		@(negedge clk);
		cfg_index <= rsac_pkg::REG_MODULUS;
		cfg_data <= modulus;
		@(negedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= $urandom();
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_dir = dir;
		cur_mod = modulus;
		if (dir == rsac_pkg::DIR_ENCRYPT)
			cipher_pool.delete();
	endtask

	// Random requests shaped by the current direction
	task automatic feed(input int count);
		logic [rsac_pkg::DATA_BITS-1:0] d;
		int roll;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			d = $urandom();
			if (cur_dir == rsac_pkg::DIR_ENCRYPT) begin
				if (roll < 85)
					d[7:0] = CHAR_SET[$urandom_range(0, 41)];
			end else begin
				if (roll < 50 && cipher_pool.size() != 0)
					d = cipher_pool[$urandom_range(0, cipher_pool.size() - 1)];
				else if (roll < 70)
					d = $urandom_range(0, 50);
				else if (roll < 85)
					d = $urandom_range(0, cur_mod - 1);
			end
			push(d);
		end
	endtask

	initial begin
		logic [31:0] enc_edge[16] = '{32'h41, 32'h5A, 32'h30, 32'h39, 32'h61, 32'h66,
			32'h40, 32'h5B, 32'h2F, 32'h3A, 32'h60, 32'h67, 32'h00, 32'hFF,
			32'hFFFFFF41, 32'h80000066};
		logic [31:0] dec_edge[6] = '{32'd1, 32'd0, 32'd186, 32'd42, 32'hFFFFFFFF, 32'd188};
		logic        dir;
		logic [31:0] expo;
		logic [31:0] modulus;
		bit          wide;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Table edges, characters outside it and ignored high bits, reset keys
		foreach (enc_edge[i])
			push(enc_edge[i]);
		// Decrypt edges with the matching private exponent
		set_keys(rsac_pkg::DIR_DECRYPT, 32'd23, 32'd187);
		foreach (dec_edge[i])
			push(dec_edge[i]);

		// Round trips on two small key pairs
		set_keys(rsac_pkg::DIR_ENCRYPT, 32'd7, 32'd187);
		feed(200);
		set_keys(rsac_pkg::DIR_DECRYPT, 32'd23, 32'd187);
		feed(200);
		set_keys(rsac_pkg::DIR_ENCRYPT, 32'd17, 32'd3233);
		feed(120);
		set_keys(rsac_pkg::DIR_DECRYPT, 32'd2753, 32'd3233);
		feed(120);

		// Zero exponent, modulus of one, wrapping zero modulus
		set_keys(rsac_pkg::DIR_ENCRYPT, 32'd0, $urandom());
		feed(20);
		set_keys(rsac_pkg::DIR_DECRYPT, 32'd0, 32'd5000);
		feed(15);
		set_keys(rsac_pkg::DIR_ENCRYPT, 32'd13, 32'd1);
		feed(15);
		set_keys(rsac_pkg::DIR_DECRYPT, 32'd13, 32'd1);
		feed(15);
		set_keys(rsac_pkg::DIR_ENCRYPT, $urandom() >> 24, 32'd0);
		feed(30);
		set_keys(rsac_pkg::DIR_DECRYPT, 32'd9, 32'd0);
		feed(30);

		// Full-width keys and the smallest legal modulus
		set_keys(rsac_pkg::DIR_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF);
		feed(8);
		set_keys(rsac_pkg::DIR_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF);
		feed(4);
		set_keys(rsac_pkg::DIR_ENCRYPT, $urandom(), 32'd2);
		feed(10);
		set_keys(rsac_pkg::DIR_DECRYPT, 32'd1, 32'd2);
		feed(10);

		// Random key sets, mostly short exponents
		while (sent < N_ITEMS) begin
			dir = 1'($urandom_range(0, 1));
			wide = ($urandom_range(0, 9) == 0);
			expo = wide ? ($urandom() | 32'h80000000) : ($urandom() >> $urandom_range(20, 31));
			modulus = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(2, 400);
			set_keys(dir, expo, modulus);
			feed(wide ? 5 : $urandom_range(30, 60));
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY_MAX) @(negedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
